/* rtl/ffba_pkg.sv */
// Package with shared types, constants and command codes of the block allocator.
package ffba_pkg;

  localparam int unsigned HeapDepthDefault    = 4096;
  localparam int unsigned HeaderBlocksDefault = 1;
  localparam int unsigned TypeSlotsDefault    = 16;

  localparam logic [15:0] NoRun = 16'hFFFF;

  localparam logic CmdAlloc   = 1'b0;
  localparam logic CmdRelease = 1'b1;

  localparam logic CfgBlockSizeLog2 = 1'b0;
  localparam logic CfgHeapBlocks    = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SETUP,
    ST_A_READ,
    ST_A_WAIT,
    ST_A_CHECK,
    ST_A_PREV_RD,
    ST_A_PREV_WAIT,
    ST_A_PREV_WR,
    ST_A_WRITE,
    ST_A_FINISH,
    ST_R_SIZE_RD,
    ST_R_SIZE_WAIT,
    ST_R_READ,
    ST_R_WAIT,
    ST_R_CHECK,
    ST_R_LINK,
    ST_R_MRG_NXT_RD,
    ST_R_MRG_NXT_WAIT,
    ST_R_MRG_NXT_WR,
    ST_R_PREV_RD,
    ST_R_PREV_WAIT,
    ST_R_PREV_WR,
    ST_R_MRG_PRV_RD,
    ST_R_MRG_PRV_WAIT,
    ST_R_MRG_PRV_WR,
    ST_R_FINISH,
    ST_OUT
  } ffba_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_RD_CUR,
    OP_RD_PREV,
    OP_RD_BLK,
    OP_RD_NXT,
    OP_A_STEP,
    OP_A_PREV_WR,
    OP_A_SPLIT,
    OP_A_FINISH,
    OP_R_STEP,
    OP_R_LINK,
    OP_R_MRG_NXT_WR,
    OP_R_PREV_WR,
    OP_R_MRG_PRV_WR
  } ffba_op_t;

  typedef struct packed {
    ffba_op_t op;
    logic     finish_rel;
    logic     emit;
  } ffba_cmd_t;

  typedef struct packed {
    logic cmd_rel;
    logic heap_ready;
    logic walk_end;
    logic fit;
    logic exact;
    logic prev_none;
    logic nxt_none;
    logic touch_nxt;
    logic touch_prev;
    logic dup;
    logic blk_in;
    logic out_busy;
  } ffba_stat_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] sat_sub16(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : 16'd0;
  endfunction

endpackage

/* rtl/ffba_if.sv */
// Valid/ready channel interfaces for requests and results of the allocator.
interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] size_bytes;
  logic [3:0]  mem_type;
  logic [15:0] handle_in;
  modport source (output valid, cmd, size_bytes, mem_type, handle_in, input ready);
  modport sink (input valid, cmd, size_bytes, mem_type, handle_in, output ready);
endinterface

interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] handle_out;
  logic        status;
  logic [15:0] free_total;
  logic [15:0] alloc_count;
  logic [15:0] type_count;
  logic [15:0] type_blocks;
  modport source (output valid, handle_out, status, free_total, alloc_count, type_count,
                  type_blocks, input ready);
  modport sink (input valid, handle_out, status, free_total, alloc_count, type_count,
                type_blocks, output ready);
endinterface

/* rtl/ffba_ctrl.sv */
// Controller state machine sequencing list walks and header updates.
module ffba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffba_pkg::ffba_stat_t stat,
  output ffba_pkg::ffba_cmd_t  cmd
);
  import ffba_pkg::*;

  ffba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (stat.cmd_rel) begin
          state_nxt = (stat.heap_ready && stat.blk_in) ? ST_R_SIZE_RD : ST_OUT;
        end else begin
          state_nxt = ST_A_READ;
        end
      end
      ST_A_READ:  state_nxt = ST_A_WAIT;
      ST_A_WAIT:  state_nxt = ST_A_CHECK;
      ST_A_CHECK: begin
        if (stat.walk_end) begin
          state_nxt = ST_OUT;
        end else if (stat.fit) begin
          state_nxt = (stat.exact && !stat.prev_none) ? ST_A_PREV_RD : ST_A_WRITE;
        end else begin
          state_nxt = ST_A_READ;
        end
      end
      ST_A_PREV_RD:   state_nxt = ST_A_PREV_WAIT;
      ST_A_PREV_WAIT: state_nxt = ST_A_PREV_WR;
      ST_A_PREV_WR:   state_nxt = ST_A_WRITE;
      ST_A_WRITE:     state_nxt = ST_A_FINISH;
      ST_A_FINISH:    state_nxt = ST_OUT;
      ST_R_SIZE_RD:   state_nxt = ST_R_SIZE_WAIT;
      ST_R_SIZE_WAIT: state_nxt = ST_R_READ;
      ST_R_READ:      state_nxt = ST_R_WAIT;
      ST_R_WAIT:      state_nxt = ST_R_CHECK;
      ST_R_CHECK: begin
        if (stat.dup) begin
          state_nxt = ST_OUT;
        end else if (stat.walk_end) begin
          state_nxt = ST_R_LINK;
        end else begin
          state_nxt = ST_R_READ;
        end
      end
      ST_R_LINK: begin
        if (!stat.nxt_none) begin
          state_nxt = ST_R_MRG_NXT_RD;
        end else if (!stat.prev_none) begin
          state_nxt = ST_R_PREV_RD;
        end else begin
          state_nxt = ST_R_FINISH;
        end
      end
      ST_R_MRG_NXT_RD:   state_nxt = ST_R_MRG_NXT_WAIT;
      ST_R_MRG_NXT_WAIT: state_nxt = ST_R_MRG_NXT_WR;
      ST_R_MRG_NXT_WR:   state_nxt = stat.prev_none ? ST_R_FINISH : ST_R_PREV_RD;
      ST_R_PREV_RD:      state_nxt = ST_R_PREV_WAIT;
      ST_R_PREV_WAIT:    state_nxt = ST_R_PREV_WR;
      ST_R_PREV_WR:      state_nxt = ST_R_MRG_PRV_RD;
      ST_R_MRG_PRV_RD:   state_nxt = ST_R_MRG_PRV_WAIT;
      ST_R_MRG_PRV_WAIT: state_nxt = ST_R_MRG_PRV_WR;
      ST_R_MRG_PRV_WR:   state_nxt = ST_R_FINISH;
      ST_R_FINISH:       state_nxt = ST_OUT;
      ST_OUT: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.op         = OP_NONE;
    cmd.finish_rel = 1'b0;
    cmd.emit       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      ST_SETUP:          cmd.op = OP_SETUP;
      ST_A_READ:         cmd.op = OP_RD_CUR;
      ST_A_CHECK:        cmd.op = OP_A_STEP;
      ST_A_PREV_RD:      cmd.op = OP_RD_PREV;
      ST_A_PREV_WR:      cmd.op = OP_A_PREV_WR;
      ST_A_WRITE:        cmd.op = OP_A_SPLIT;
      ST_A_FINISH:       cmd.op = OP_A_FINISH;
      ST_R_SIZE_RD:      cmd.op = OP_RD_BLK;
      ST_R_READ:         cmd.op = OP_RD_CUR;
      ST_R_CHECK:        cmd.op = OP_R_STEP;
      ST_R_LINK:         cmd.op = OP_R_LINK;
      ST_R_MRG_NXT_RD:   cmd.op = OP_RD_NXT;
      ST_R_MRG_NXT_WR:   cmd.op = OP_R_MRG_NXT_WR;
      ST_R_PREV_RD:      cmd.op = OP_RD_PREV;
      ST_R_PREV_WR:      cmd.op = OP_R_PREV_WR;
      ST_R_MRG_PRV_RD:   cmd.op = OP_RD_BLK;
      ST_R_MRG_PRV_WR:   cmd.op = OP_R_MRG_PRV_WR;
      ST_R_FINISH:       cmd.finish_rel = 1'b1;
      ST_OUT:            cmd.emit = !stat.out_busy;
      default:           cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/ffba_dpath.sv */
// Datapath with the header memory, walk registers, counters and result register.
module ffba_dpath #(
  parameter int unsigned HEAP_DEPTH    = ffba_pkg::HeapDepthDefault,
  parameter int unsigned HEADER_BLOCKS = ffba_pkg::HeaderBlocksDefault,
  parameter int unsigned TYPE_SLOTS    = ffba_pkg::TypeSlotsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 req_cmd,
  input  logic [15:0]          req_size_bytes,
  input  logic [3:0]           req_mem_type,
  input  logic [15:0]          req_handle_in,
  input  ffba_pkg::ffba_cmd_t  cmd,
  output ffba_pkg::ffba_stat_t stat,
  ffba_rsp_if.source           rsp
);
  import ffba_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int SW = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
  localparam logic [16:0] DepthC = 17'(HEAP_DEPTH);
  localparam logic [15:0] HdrC   = 16'(HEADER_BLOCKS);

  logic [31:0] mem [HEAP_DEPTH];
  logic [31:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;
  logic        mem_re;

  logic [2:0]  lg_r;
  logic [15:0] hb_r;
  logic        cmd_r;
  logic [15:0] size_r, handle_r, need_r, blk_r, cur_r, prev_r, nxt_r, sz_r, steps_r;
  logic [SW-1:0] slot_r;
  logic [15:0] head_r, free_sum_r, live_r;
  logic        ready_r;
  logic [15:0] tcount_r [TYPE_SLOTS];
  logic [15:0] tblocks_r [TYPE_SLOTS];
  logic        found_r;
  logic        v_r;
  logic [15:0] o_handle_r, o_free_r, o_live_r, o_tc_r, o_tb_r;
  logic        o_status_r;

  logic [15:0] rd_next, rd_size;
  logic [2:0]  lg_sat;
  logic [16:0] round;
  logic [15:0] blk_calc;

  assign rd_next = rdata_r[31:16];
  assign rd_size = rdata_r[15:0];

  function automatic logic in_heap(input logic [15:0] a);
    return {1'b0, a} < DepthC;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= 3'd2;
      hb_r <= 16'd4096;
    end else if (cfg_we) begin
      if (cfg_index == CfgBlockSizeLog2) begin
        lg_r <= cfg_wdata[2:0];
      end else begin
        hb_r <= cfg_wdata;
      end
    end
  end

  assign lg_sat   = (lg_r < 3'd2) ? 3'd2 : ((lg_r > 3'd4) ? 3'd4 : lg_r);
  assign round    = ({1'b0, size_r} + ((17'd1 << lg_sat) - 17'd1)) >> lg_sat;
  assign blk_calc = handle_r - HdrC;

  // Walk status.
  always_comb begin
    stat.cmd_rel    = cmd_r;
    stat.heap_ready = ready_r;
    stat.blk_in     = in_heap(blk_calc);
    stat.walk_end   = (cur_r == NoRun) || !in_heap(cur_r) || ({1'b0, steps_r} >= DepthC);
    stat.fit        = rd_size >= need_r;
    stat.exact      = rd_size == need_r;
    stat.prev_none  = prev_r == NoRun;
    stat.nxt_none   = nxt_r == NoRun;
    stat.touch_nxt  = 1'b0;
    stat.touch_prev = 1'b0;
    stat.dup        = !stat.walk_end && (cur_r == blk_r);
    stat.out_busy   = v_r && !rsp.ready;
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = blk_r[AW-1:0];
    mem_wdata = 32'd0;
    mem_re    = 1'b0;
    mem_raddr = cur_r[AW-1:0];
    case (cmd.op)
      OP_SETUP: begin
        if (!cmd_r && !ready_r) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {NoRun, ({1'b0, hb_r} < DepthC) ? hb_r : DepthC[15:0]};
        end
      end
      OP_RD_CUR: begin
        mem_re = 1'b1;
      end
      OP_RD_PREV: begin
        mem_re    = 1'b1;
        mem_raddr = prev_r[AW-1:0];
      end
      OP_RD_BLK: begin
        mem_re    = 1'b1;
        mem_raddr = blk_r[AW-1:0];
      end
      OP_RD_NXT: begin
        mem_re    = 1'b1;
        mem_raddr = nxt_r[AW-1:0];
      end
      OP_A_PREV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = prev_r[AW-1:0];
        mem_wdata = {nxt_r, rd_size};
      end
      OP_A_SPLIT: begin
        if (sz_r != need_r) begin
          mem_we    = 1'b1;
          mem_waddr = cur_r[AW-1:0];
          mem_wdata = {nxt_r, sz_r - need_r};
        end
      end
      OP_A_FINISH: begin
        mem_we    = 1'b1;
        mem_waddr = blk_r[AW-1:0];
        mem_wdata = {NoRun, need_r};
      end
      OP_R_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = {nxt_r, sz_r};
      end
      OP_R_MRG_NXT_WR: begin
        if (blk_r + sz_r == nxt_r) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_next, sat_add16(sz_r, rd_size)};
        end
      end
      OP_R_PREV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = prev_r[AW-1:0];
        mem_wdata = {blk_r, rd_size};
      end
      OP_R_MRG_PRV_WR: begin
        if (prev_r + nxt_r == blk_r) begin
          mem_we    = 1'b1;
          mem_waddr = prev_r[AW-1:0];
          mem_wdata = {rd_next, sat_add16(nxt_r, rd_size)};
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  // In the release path, sz_r holds the released run's size; during the previous-run
  // merge nxt_r is reused to hold the previous run's size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= NoRun;
      ready_r    <= 1'b0;
      free_sum_r <= '0;
      live_r     <= '0;
      v_r        <= 1'b0;
      for (int i = 0; i < TYPE_SLOTS; i++) begin
        tcount_r[i]  <= '0;
        tblocks_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          cmd_r    <= req_cmd;
          size_r   <= req_size_bytes;
          handle_r <= req_handle_in;
          slot_r   <= ({28'd0, req_mem_type} < 32'(TYPE_SLOTS)) ? req_mem_type[SW-1:0] : '0;
          found_r  <= 1'b0;
        end
        OP_SETUP: begin
          need_r  <= round[15:0] + HdrC;
          prev_r  <= NoRun;
          nxt_r   <= NoRun;
          steps_r <= '0;
          blk_r   <= blk_calc;
          if (!cmd_r && !ready_r) begin
            ready_r    <= 1'b1;
            head_r     <= '0;
            cur_r      <= '0;
            free_sum_r <= ({1'b0, hb_r} < DepthC) ? hb_r : DepthC[15:0];
          end else begin
            cur_r <= head_r;
          end
        end
        OP_A_STEP: begin
          steps_r <= steps_r + 16'd1;
          if (stat.walk_end) begin
            steps_r <= steps_r + 16'd1;
          end else if (stat.fit) begin
            sz_r  <= rd_size;
            nxt_r <= rd_next;
            if (stat.exact) begin
              blk_r <= cur_r;
              if (stat.prev_none) begin
                head_r <= rd_next;
              end
            end else begin
              blk_r <= cur_r + (rd_size - need_r);
            end
          end else begin
            prev_r <= cur_r;
            cur_r  <= rd_next;
          end
        end
        OP_A_PREV_WR: begin
          sz_r <= need_r;
        end
        OP_A_FINISH: begin
          live_r            <= sat_add16(live_r, 16'd1);
          free_sum_r        <= sat_sub16(free_sum_r, need_r);
          tcount_r[slot_r]  <= sat_add16(tcount_r[slot_r], 16'd1);
          tblocks_r[slot_r] <= sat_add16(tblocks_r[slot_r], need_r);
          found_r           <= 1'b1;
        end
        OP_R_STEP: begin
          if (stat.walk_end) begin
            steps_r <= steps_r;
          end else begin
            steps_r <= steps_r + 16'd1;
            if (cur_r != blk_r) begin
              if (blk_r < cur_r) begin
                nxt_r <= cur_r;
                cur_r <= NoRun;
              end else begin
                prev_r <= cur_r;
                cur_r  <= rd_next;
              end
            end
          end
        end
        OP_R_LINK: begin
          if (prev_r == NoRun) begin
            head_r <= blk_r;
          end
        end
        OP_R_MRG_PRV_WR: begin
          nxt_r <= nxt_r;
        end
        default: begin
        end
      endcase
      // Captures from the read data register, release counter updates and the result register.
      if (cmd.op == OP_RD_CUR && cmd_r && steps_r == 16'd0 && !found_r) begin
        sz_r    <= rd_size;
        found_r <= 1'b1;
      end
      if (cmd.op == OP_R_PREV_WR) begin
        nxt_r <= rd_size;
      end
      if (cmd.finish_rel) begin
        live_r            <= sat_sub16(live_r, 16'd1);
        free_sum_r        <= sat_add16(free_sum_r, sz_r);
        tcount_r[slot_r]  <= sat_sub16(tcount_r[slot_r], 16'd1);
        tblocks_r[slot_r] <= sat_sub16(tblocks_r[slot_r], sz_r);
      end
      if (cmd.emit) begin
        v_r        <= 1'b1;
        o_handle_r <= (!cmd_r && found_r) ? (blk_r + HdrC) : NoRun;
        o_status_r <= !cmd_r && !found_r;
        o_free_r   <= free_sum_r;
        o_live_r   <= live_r;
        o_tc_r     <= tcount_r[slot_r];
        o_tb_r     <= tblocks_r[slot_r];
      end else if (rsp.ready) begin
        v_r <= 1'b0;
      end
    end
  end

  assign rsp.valid       = v_r;
  assign rsp.handle_out  = o_handle_r;
  assign rsp.status      = o_status_r;
  assign rsp.free_total  = o_free_r;
  assign rsp.alloc_count = o_live_r;
  assign rsp.type_count  = o_tc_r;
  assign rsp.type_blocks = o_tb_r;

endmodule

/* rtl/first_fit_block_allocator_unit.sv */
// Top level of the first-fit block allocator with address-ordered coalescing free list.
// An allocate walks the free list with one check per visited run until a run fits or the
// walk ends; an exact fit that unlinks a run behind the head also rewrites that previous
// run's header. A release walks to its place in the list, then links and merges headers; a
// release outside the heap or before the first allocate goes straight to the result.
// Throughput: one item at a time. Reset: synchronous rst_n clears counters and list head.
module first_fit_block_allocator_unit #(
  parameter int unsigned HEAP_DEPTH    = ffba_pkg::HeapDepthDefault,
  parameter int unsigned HEADER_BLOCKS = ffba_pkg::HeaderBlocksDefault,
  parameter int unsigned TYPE_SLOTS    = ffba_pkg::TypeSlotsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  ffba_req_if.sink    in_ch,
  ffba_rsp_if.source  out_ch
);
  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffba_dpath #(
    .HEAP_DEPTH    (HEAP_DEPTH),
    .HEADER_BLOCKS (HEADER_BLOCKS),
    .TYPE_SLOTS    (TYPE_SLOTS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .req_cmd        (in_ch.cmd),
    .req_size_bytes (in_ch.size_bytes),
    .req_mem_type   (in_ch.mem_type),
    .req_handle_in  (in_ch.handle_in),
    .cmd            (cmd),
    .stat           (stat),
    .rsp            (out_ch)
  );

endmodule
